/* rtl/lfc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the LRU flow cache with top-K list.
// Used by the cache cell, the top list cell and the top level.
package lfc_pkg;

  localparam int CacheN  = 256;
  localparam int TopN    = 16;
  localparam int KeyW    = 64;
  localparam int TotalW  = 48;
  localparam int DirW    = 40;
  localparam int TimeW   = 32;
  localparam int BytesW  = 32;
  localparam int KindW   = 2;
  localparam int RankW   = 4;
  localparam int TopIdxW = (TopN > 1) ? $clog2(TopN) : 1;
  localparam int TopCntW = $clog2(TopN + 1);

  localparam logic CMD_HIT    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_HIT   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } lfc_kind_e;

  // Where a top list cell takes its next content from.
  typedef enum logic [1:0] {
    SEL_KEEP,
    SEL_UP,
    SEL_DOWN,
    SEL_NEW
  } lfc_sel_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [TotalW-1:0] total;
    logic [DirW-1:0]   ab;
    logic [DirW-1:0]   ba;
    logic [TimeW-1:0]  seen;
  } lfc_rec_t;

  typedef struct packed {
    logic     valid;
    lfc_rec_t rec;
  } lfc_slot_t;

endpackage

/* rtl/lfc_cache_cell.sv */
`timescale 1ns / 1ps
// One cell of the recency chain: holds one flow record and compares its key.
// Depends on lfc_pkg.
module lfc_cache_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  lfc_pkg::lfc_slot_t        prev_i,
  input  logic [lfc_pkg::KeyW-1:0]  key_i,
  output lfc_pkg::lfc_slot_t        slot_o,
  output logic                      match_o
);
  import lfc_pkg::*;

  logic     valid_q;
  lfc_rec_t rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= prev_i.rec;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.rec   = rec_q;
  assign match_o      = valid_q && (rec_q.key == key_i);

endmodule

/* rtl/lfc_top_cell.sv */
`timescale 1ns / 1ps
// One cell of the sorted top list: holds one record, compares its key and
// ranks itself against the updated record. Depends on lfc_pkg.
module lfc_top_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lfc_pkg::lfc_sel_e         sel_i,
  input  lfc_pkg::lfc_slot_t        down_i,
  input  lfc_pkg::lfc_slot_t        up_i,
  input  lfc_pkg::lfc_rec_t         new_i,
  input  logic [lfc_pkg::KeyW-1:0]  key_i,
  output lfc_pkg::lfc_slot_t        slot_o,
  output logic                      match_o,
  output logic                      ge_o,
  output logic                      gt_o
);
  import lfc_pkg::*;

  logic     valid_q;
  lfc_rec_t rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      unique case (sel_i)
        SEL_UP:   valid_q <= up_i.valid;
        SEL_DOWN: valid_q <= down_i.valid;
        SEL_NEW:  valid_q <= 1'b1;
        default:  valid_q <= valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (sel_i)
      SEL_UP:   rec_q <= up_i.rec;
      SEL_DOWN: rec_q <= down_i.rec;
      SEL_NEW:  rec_q <= new_i;
      default:  rec_q <= rec_q;
    endcase
  end

  assign slot_o.valid = valid_q;
  assign slot_o.rec   = rec_q;
  assign match_o      = valid_q && (rec_q.key == key_i);
  // Rank by total first, then by the later timestamp.
  assign ge_o = (new_i.total > rec_q.total) ||
                ((new_i.total == rec_q.total) && (new_i.seen >= rec_q.seen));
  assign gt_o = (new_i.total > rec_q.total) ||
                ((new_i.total == rec_q.total) && (new_i.seen > rec_q.seen));

endmodule

/* rtl/lru_flow_cache_top_k.sv */
`timescale 1ns / 1ps
// LRU flow cache with a sorted top-K heavy-hitter list.
// Depends on lfc_pkg, lfc_cache_cell and lfc_top_cell.
//
// Usage: a command transfer happens at a rising edge with start_i high and
// busy_o low. A hit command (command_i = 0) finds or allocates the flow
// record, moves it to the head of the recency chain, adds the byte counts
// with saturation and updates the top list. It passes through the busy
// states match, fetch with removal of an evicted record from the list, add,
// and chain shift together with list insert. Its single reply is strobed in
// the cycle in which busy_o is low again, and the next command can be
// accepted at the end of that cycle, so hits do not overlap. A report
// command (command_i = 1) emits one result per cycle, lowest total first,
// the first one starting at the edge after the accepting edge; it keeps the
// block busy until the last list entry has been emitted. An empty list
// gives a single reply of kind empty in the cycle right after the accepting
// edge and leaves the block free. Each result is shown for exactly one
// cycle and the receiver cannot stall it. Reset empties the cache and the
// list at once; no clearing pass is needed.
module lru_flow_cache_top_k (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         command_i,
  input  logic [lfc_pkg::KeyW-1:0]     flow_key_i,
  input  logic [lfc_pkg::TimeW-1:0]    event_time_i,
  input  logic [lfc_pkg::BytesW-1:0]   bytes_ab_i,
  input  logic [lfc_pkg::BytesW-1:0]   bytes_ba_i,
  output logic                         result_strobe_o,
  output logic [lfc_pkg::KindW-1:0]    reply_kind_o,
  output logic [lfc_pkg::KeyW-1:0]     entry_key_o,
  output logic [lfc_pkg::TotalW-1:0]   total_count_o,
  output logic [lfc_pkg::DirW-1:0]     total_ab_o,
  output logic [lfc_pkg::DirW-1:0]     total_ba_o,
  output logic [lfc_pkg::TimeW-1:0]    last_seen_o,
  output logic [lfc_pkg::RankW-1:0]    rank_o,
  output logic                         was_cached_o,
  output logic                         in_top_o,
  output logic                         did_evict_o,
  output logic [lfc_pkg::KeyW-1:0]     evicted_key_o,
  output logic                         last_of_run_o
);
  import lfc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MATCH  = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_UPD    = 3'd3;
  localparam logic [2:0] ST_TOP    = 3'd4;
  localparam logic [2:0] ST_REPORT = 3'd5;

  localparam int TotSumW = TotalW + 1;
  localparam int DirSumW = DirW + 1;
  localparam int RecW    = $bits(lfc_rec_t);

  logic [2:0]         state_q, state_d;
  logic [TopIdxW-1:0] rep_idx_q;

  logic [KeyW-1:0]   key_q, evkey_q;
  logic [TimeW-1:0]  time_q;
  logic [BytesW-1:0] ab_q, ba_q;
  logic [CacheN-1:0] match_q;
  logic              found_q, evict_q;
  lfc_rec_t          old_q, new_q;

  // Recency chain, cell 0 is the most recent record.
  lfc_slot_t         cache_slot [CacheN];
  lfc_slot_t         cache_prev [CacheN];
  logic [CacheN-1:0] cmatch, cshift;
  lfc_slot_t         new_slot;
  logic [RecW-1:0]   fetch_v;

  // Top list, cell 0 holds the lowest ranked record.
  lfc_slot_t         tslot [TopN];
  lfc_slot_t         tdown [TopN];
  lfc_slot_t         tup   [TopN];
  lfc_sel_e          tsel  [TopN];
  logic [TopN-1:0]   tmatch, tge, tgt, tvalid, belowp, rm, rm_mask;
  logic [TopN:0]     above, above_dn, tv_ext;
  logic [KeyW-1:0]   tkey;
  logic              present, overflow, join_ok;
  logic [TopCntW-1:0] qcnt;
  logic              ins_top;
  logic [TopCntW-1:0] ins_rank;
  logic              rep_last;

  logic [TotSumW-1:0] tot_sum;
  logic [DirSumW-1:0] ab_sum, ba_sum;

  assign busy_o = (state_q != ST_IDLE);

  // ---------------- recency chain ----------------
  assign new_slot.valid = 1'b1;
  assign new_slot.rec   = new_q;

  always_comb begin
    cache_prev[0] = new_slot;
    for (int i = 1; i < CacheN; i++) begin
      cache_prev[i] = cache_slot[i-1];
    end
  end

  // A hit shifts the cells up to the hit; a miss shifts the whole chain.
  assign cshift = (state_q == ST_TOP) ? (match_q | (match_q - CacheN'(1))) : '0;

  for (genvar g = 0; g < CacheN; g++) begin : g_cache
    lfc_cache_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (cshift[g]),
      .prev_i  (cache_prev[g]),
      .key_i   (key_q),
      .slot_o  (cache_slot[g]),
      .match_o (cmatch[g])
    );
  end

  always_comb begin
    fetch_v = '0;
    for (int i = 0; i < CacheN; i++) begin
      fetch_v = fetch_v | (cache_slot[i].rec & {RecW{match_q[i]}});
    end
  end

  assign tot_sum = TotSumW'(old_q.total) + TotSumW'(ab_q) + TotSumW'(ba_q);
  assign ab_sum  = DirSumW'(old_q.ab) + DirSumW'(ab_q);
  assign ba_sum  = DirSumW'(old_q.ba) + DirSumW'(ba_q);

  // ---------------- top list ----------------
  assign tkey = (state_q == ST_FETCH) ? evkey_q : new_q.key;

  always_comb begin
    for (int i = 0; i < TopN; i++) begin
      tvalid[i] = tslot[i].valid;
      tup[i]    = (i == TopN - 1) ? lfc_slot_t'('0) : tslot[(i + 1) % TopN];
      tdown[i]  = (i == 0) ? lfc_slot_t'('0) : tslot[(i + TopN - 1) % TopN];
    end
  end

  for (genvar g = 0; g < TopN; g++) begin : g_top
    lfc_top_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sel_i   (tsel[g]),
      .down_i  (tdown[g]),
      .up_i    (tup[g]),
      .new_i   (new_q),
      .key_i   (tkey),
      .slot_o  (tslot[g]),
      .match_o (tmatch[g]),
      .ge_o    (tge[g]),
      .gt_o    (tgt[g])
    );
  end

  always_comb begin
    present  = |tmatch;
    belowp   = tmatch - TopN'(1);
    overflow = !present && tvalid[TopN-1];
    join_ok  = present || !tvalid[TopN-1] || (new_q.total >= tslot[0].rec.total);
    rm       = (evict_q && (state_q == ST_FETCH)) ? tmatch : '0;
    rm_mask  = ~(rm - TopN'(1));
    above    = '0;
    // An updated record stays below its exact equals that sat above it;
    // a newly joining record goes above its equals.
    for (int j = 0; j < TopN; j++) begin
      above[j] = tvalid[j] && !tmatch[j] &&
                 ((present && !belowp[j]) ? tgt[j] : tge[j]);
    end
    above_dn = {above[TopN-1:0], 1'b1};
    qcnt = '0;
    for (int j = 0; j < TopN; j++) begin
      qcnt = qcnt + TopCntW'(above[j]);
    end
    for (int j = 0; j < TopN; j++) begin
      tsel[j] = SEL_KEEP;
      if (state_q == ST_FETCH) begin
        if (rm_mask[j]) tsel[j] = SEL_UP;
      end else if ((state_q == ST_TOP) && join_ok) begin
        if (present) begin
          priority if (belowp[j])              tsel[j] = SEL_KEEP;
          else if (above[j+1])                 tsel[j] = SEL_UP;
          else if (tmatch[j] || above[j])      tsel[j] = SEL_NEW;
          else                                 tsel[j] = SEL_KEEP;
        end else if (overflow) begin
          priority if (above[j+1])             tsel[j] = SEL_UP;
          else if (above[j])                   tsel[j] = SEL_NEW;
          else                                 tsel[j] = SEL_KEEP;
        end else begin
          priority if (above[j])               tsel[j] = SEL_KEEP;
          else if (above_dn[j])                tsel[j] = SEL_NEW;
          else                                 tsel[j] = SEL_DOWN;
        end
      end
    end
    if (!join_ok) begin
      ins_top  = 1'b0;
      ins_rank = '0;
    end else if (overflow) begin
      ins_top  = (qcnt != '0);
      ins_rank = (qcnt != '0) ? (qcnt - TopCntW'(1)) : '0;
    end else begin
      ins_top  = 1'b1;
      ins_rank = qcnt;
    end
  end

  assign tv_ext   = {1'b0, tvalid};
  assign rep_last = !tv_ext[TopCntW'(rep_idx_q) + TopCntW'(1)];

  // ---------------- control ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (command_i == CMD_HIT) state_d = ST_MATCH;
          else if (tvalid[0])       state_d = ST_REPORT;
        end
      end
      ST_MATCH:  state_d = ST_FETCH;
      ST_FETCH:  state_d = ST_UPD;
      ST_UPD:    state_d = ST_TOP;
      ST_TOP:    state_d = ST_IDLE;
      ST_REPORT: begin
        if (rep_last) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      rep_idx_q       <= '0;
      result_strobe_o <= 1'b0;
    end else begin
      state_q         <= state_d;
      result_strobe_o <= 1'b0;
      if (state_q == ST_IDLE) begin
        rep_idx_q <= '0;
        if (start_i && (command_i == CMD_REPORT) && !tvalid[0]) result_strobe_o <= 1'b1;
      end
      if (state_q == ST_REPORT) begin
        rep_idx_q       <= rep_idx_q + TopIdxW'(1);
        result_strobe_o <= 1'b1;
      end
      if (state_q == ST_TOP) result_strobe_o <= 1'b1;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_q  <= flow_key_i;
          time_q <= event_time_i;
          ab_q   <= bytes_ab_i;
          ba_q   <= bytes_ba_i;
          if ((command_i == CMD_REPORT) && !tvalid[0]) begin
            reply_kind_o  <= KIND_EMPTY;
            entry_key_o   <= '0;
            total_count_o <= '0;
            total_ab_o    <= '0;
            total_ba_o    <= '0;
            last_seen_o   <= '0;
            rank_o        <= '0;
            was_cached_o  <= 1'b0;
            in_top_o      <= 1'b0;
            did_evict_o   <= 1'b0;
            evicted_key_o <= '0;
            last_of_run_o <= 1'b1;
          end
        end
      end
      ST_MATCH: begin
        match_q <= cmatch;
        found_q <= |cmatch;
        evict_q <= !(|cmatch) && cache_slot[CacheN-1].valid;
        evkey_q <= cache_slot[CacheN-1].rec.key;
      end
      ST_FETCH: begin
        old_q <= lfc_rec_t'(fetch_v);
      end
      ST_UPD: begin
        new_q.key   <= key_q;
        new_q.total <= tot_sum[TotalW] ? {TotalW{1'b1}} : tot_sum[TotalW-1:0];
        new_q.ab    <= ab_sum[DirW] ? {DirW{1'b1}} : ab_sum[DirW-1:0];
        new_q.ba    <= ba_sum[DirW] ? {DirW{1'b1}} : ba_sum[DirW-1:0];
        new_q.seen  <= (time_q > old_q.seen) ? time_q : old_q.seen;
      end
      ST_TOP: begin
        reply_kind_o  <= KIND_HIT;
        entry_key_o   <= new_q.key;
        total_count_o <= new_q.total;
        total_ab_o    <= new_q.ab;
        total_ba_o    <= new_q.ba;
        last_seen_o   <= new_q.seen;
        rank_o        <= RankW'(ins_rank);
        was_cached_o  <= found_q;
        in_top_o      <= ins_top;
        did_evict_o   <= evict_q;
        evicted_key_o <= evict_q ? evkey_q : '0;
        last_of_run_o <= 1'b1;
      end
      ST_REPORT: begin
        reply_kind_o  <= KIND_ENTRY;
        entry_key_o   <= tslot[rep_idx_q].rec.key;
        total_count_o <= tslot[rep_idx_q].rec.total;
        total_ab_o    <= tslot[rep_idx_q].rec.ab;
        total_ba_o    <= tslot[rep_idx_q].rec.ba;
        last_seen_o   <= tslot[rep_idx_q].rec.seen;
        rank_o        <= RankW'(rep_idx_q);
        was_cached_o  <= 1'b0;
        in_top_o      <= 1'b0;
        did_evict_o   <= 1'b0;
        evicted_key_o <= '0;
        last_of_run_o <= rep_last;
      end
      default: begin
      end
    endcase
  end

endmodule
